### sv/first_fit_boundary_tag_allocator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit allocator
// Shared concurrent assertion forms used by the allocator modules.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_ASSERT_SVH

// Implication checked every cycle outside reset.
`define FFA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define FFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/ffa_pkg.sv
// ---------------------------------------------------------------------------
// Allocator package
// Shared constants, state encoding and controller/datapath command and status types.
// ---------------------------------------------------------------------------
package ffa_pkg;

  localparam int HEAP_WORDS = 512;
  localparam int ADDR_W     = 9;
  localparam int TAG_W      = 14;
  localparam int BYTE_W     = 13;
  localparam logic [BYTE_W-1:0] HEAP_CAP   = 13'd4096;
  localparam logic [BYTE_W-1:0] HEAP_RESET = 13'd4096;
  localparam logic [BYTE_W-1:0] WORD_BYTES = 13'd8;
  localparam logic [BYTE_W-1:0] MIN_BLOCK  = 13'd16;
  localparam logic [BYTE_W-1:0] MIN_SPLIT  = 13'd24;
  localparam logic [BYTE_W-1:0] MIN_HEAP   = 13'd32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_FORMAT,
    ST_IDLE,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_EXAMINE,
    ST_SPLIT_W0,
    ST_SPLIT_W1,
    ST_SPLIT_W2,
    ST_SPLIT_W3,
    ST_WHOLE_W0,
    ST_WHOLE_W1,
    ST_NEXT_ISSUE,
    ST_NEXT_WAIT,
    ST_NEXT_EXAM,
    ST_PREV_ISSUE,
    ST_PREV_WAIT,
    ST_MERGE_W0,
    ST_MERGE_W1,
    ST_RESULT
  } state_t;

  typedef enum logic [3:0] {
    WSEL_NONE,
    WSEL_SPLIT_REM_HDR,
    WSEL_SPLIT_REM_TRL,
    WSEL_SPLIT_USE_HDR,
    WSEL_SPLIT_USE_TRL,
    WSEL_WHOLE_HDR,
    WSEL_WHOLE_TRL,
    WSEL_MERGE_HDR,
    WSEL_MERGE_TRL
  } wsel_t;

  typedef enum logic [1:0] {
    RSEL_WALK,
    RSEL_NEXT,
    RSEL_PREV
  } rsel_t;

  typedef struct packed {
    logic  clear_step;
    logic  format_write;
    logic  load_item;
    logic  rd_en;
    rsel_t rd_sel;
    logic  latch_walk;
    logic  latch_next;
    logic  latch_prev;
    logic  advance;
    wsel_t wsel;
    logic  set_fail;
    logic  set_alloc_ok;
    logic  set_free_ok;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_alloc;
    logic walk_end;
    logic fits;
    logic split_ok;
    logic past_target;
    logic at_target;
    logic next_in_heap;
    logic have_prev;
  } sts_t;

endpackage

### sv/ffa_datapath.sv
// ---------------------------------------------------------------------------
// Allocator datapath
// Tag memory, walk pointer and the size arithmetic of the block walk.
// ---------------------------------------------------------------------------
`include "first_fit_boundary_tag_allocator_assert.svh"

module ffa_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ffa_pkg::BYTE_W-1:0]     cfg_data,
  input  logic                           in_opcode,
  input  logic [11:0]                    in_request_size,
  input  logic [11:0]                    in_payload_offset,
  input  ffa_pkg::cmd_t                  cmd,
  output ffa_pkg::sts_t                  sts,
  output logic                           res_status,
  output logic [11:0]                    res_offset,
  output logic [ffa_pkg::BYTE_W-1:0]     res_bytes
);

  logic [ffa_pkg::TAG_W-1:0]  mem [ffa_pkg::HEAP_WORDS];
  logic [ffa_pkg::TAG_W-1:0]  rd_data;
  logic [ffa_pkg::BYTE_W-1:0] heap_bytes;
  logic [ffa_pkg::BYTE_W-1:0] cfg_clamped;
  logic [ffa_pkg::ADDR_W:0]   clr_cnt;
  logic                       op;
  logic [ffa_pkg::BYTE_W-1:0] need;
  logic [ffa_pkg::BYTE_W-1:0] target;
  logic                       target_ok;
  logic [ffa_pkg::BYTE_W-1:0] walk;
  logic [ffa_pkg::BYTE_W-1:0] sz;
  logic                       used;
  logic [ffa_pkg::BYTE_W-1:0] prev;
  logic [ffa_pkg::BYTE_W-1:0] prev_sz;
  logic                       have_prev;
  logic [ffa_pkg::BYTE_W-1:0] total;
  logic [ffa_pkg::BYTE_W-1:0] start;
  logic [ffa_pkg::BYTE_W-1:0] rd_addr;
  logic [ffa_pkg::BYTE_W-1:0] rd_size;
  logic                       rd_sound;
  logic                       rd_used;
  logic                       we;
  logic [ffa_pkg::BYTE_W-1:0] wbyte;
  logic [ffa_pkg::TAG_W-1:0]  wtag;
  logic [ffa_pkg::BYTE_W-1:0] rem;
  logic [ffa_pkg::BYTE_W-1:0] next_addr;
  logic [ffa_pkg::BYTE_W-1:0] walk_addr;

  always_comb begin
    cfg_clamped = {cfg_data[ffa_pkg::BYTE_W-1:3], 3'b000};
    if (cfg_clamped < ffa_pkg::MIN_HEAP) begin
      cfg_clamped = ffa_pkg::MIN_HEAP;
    end
    if (cfg_clamped > ffa_pkg::HEAP_CAP) begin
      cfg_clamped = ffa_pkg::HEAP_CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_bytes <= ffa_pkg::HEAP_RESET;
      clr_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        heap_bytes <= cfg_clamped;
        clr_cnt    <= '0;
      end else if (cmd.clear_step || cmd.format_write) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  assign rem       = sz - need;
  assign next_addr = walk + sz;

  always_comb begin
    case (cmd.rd_sel)
      ffa_pkg::RSEL_NEXT: rd_addr = next_addr;
      ffa_pkg::RSEL_PREV: rd_addr = prev;
      default:            rd_addr = walk;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data   <= mem[rd_addr[ffa_pkg::ADDR_W+2:3]];
      walk_addr <= rd_addr;
    end
  end

  assign rd_size  = {rd_data[ffa_pkg::BYTE_W-1:1], 1'b0};
  assign rd_used  = rd_data[0];
  assign rd_sound = (rd_size >= ffa_pkg::MIN_BLOCK) && (walk_addr < heap_bytes) &&
                    (rd_size <= heap_bytes - walk_addr);

  always_comb begin
    we    = 1'b1;
    wbyte = walk;
    wtag  = '0;
    case (cmd.wsel)
      ffa_pkg::WSEL_SPLIT_REM_HDR: begin
        wbyte = walk + need;
        wtag  = {1'b0, rem[ffa_pkg::BYTE_W-1:1], 1'b0};
      end
      ffa_pkg::WSEL_SPLIT_REM_TRL: begin
        wbyte = walk + sz - ffa_pkg::WORD_BYTES;
        wtag  = {1'b0, rem[ffa_pkg::BYTE_W-1:1], 1'b0};
      end
      ffa_pkg::WSEL_SPLIT_USE_HDR: begin
        wbyte = walk;
        wtag  = {1'b0, need[ffa_pkg::BYTE_W-1:1], 1'b1};
      end
      ffa_pkg::WSEL_SPLIT_USE_TRL: begin
        wbyte = walk + need - ffa_pkg::WORD_BYTES;
        wtag  = {1'b0, need[ffa_pkg::BYTE_W-1:1], 1'b1};
      end
      ffa_pkg::WSEL_WHOLE_HDR: begin
        wbyte = walk;
        wtag  = {1'b0, sz[ffa_pkg::BYTE_W-1:1], 1'b1};
      end
      ffa_pkg::WSEL_WHOLE_TRL: begin
        wbyte = walk + sz - ffa_pkg::WORD_BYTES;
        wtag  = {1'b0, sz[ffa_pkg::BYTE_W-1:1], 1'b1};
      end
      ffa_pkg::WSEL_MERGE_HDR: begin
        wbyte = start;
        wtag  = {1'b0, total[ffa_pkg::BYTE_W-1:1], 1'b0};
      end
      ffa_pkg::WSEL_MERGE_TRL: begin
        wbyte = start + total - ffa_pkg::WORD_BYTES;
        wtag  = {1'b0, total[ffa_pkg::BYTE_W-1:1], 1'b0};
      end
      default: begin
        we = 1'b0;
      end
    endcase
    if (cmd.clear_step) begin
      we    = 1'b1;
      wbyte = {1'b0, clr_cnt[ffa_pkg::ADDR_W-1:0], 3'b000};
      wtag  = '0;
    end else if (cmd.format_write) begin
      we    = 1'b1;
      wbyte = clr_cnt[0] ? heap_bytes - ffa_pkg::WORD_BYTES : '0;
      wtag  = {1'b0, heap_bytes[ffa_pkg::BYTE_W-1:1], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wbyte[ffa_pkg::ADDR_W+2:3]] <= wtag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op        <= in_opcode;
      need      <= ({1'b0, in_request_size} + 13'd7 & ~13'd7) + 13'd16;
      target    <= {1'b0, in_payload_offset} - ffa_pkg::WORD_BYTES;
      target_ok <= in_payload_offset >= 12'd8;
      walk      <= '0;
      have_prev <= 1'b0;
    end
    if (cmd.latch_walk) begin
      sz   <= rd_sound ? rd_size : '0;
      used <= rd_used;
      total <= rd_size;
      start <= walk;
    end
    if (cmd.latch_next) begin
      if (rd_sound && !rd_used) begin
        total <= total + rd_size;
      end
    end
    if (cmd.latch_prev) begin
      if (!rd_used) begin
        start <= prev;
        total <= total + prev_sz;
      end
    end
    if (cmd.advance) begin
      prev      <= walk;
      prev_sz   <= sz;
      have_prev <= 1'b1;
      walk      <= next_addr;
    end
    if (cmd.set_fail) begin
      res_status <= 1'b1;
      res_offset <= '0;
      res_bytes  <= '0;
    end
    if (cmd.set_alloc_ok) begin
      res_status <= 1'b0;
      res_offset <= walk[11:0] + 12'd8;
      res_bytes  <= (rem >= ffa_pkg::MIN_SPLIT) ? need : sz;
    end
    if (cmd.set_free_ok) begin
      res_status <= 1'b0;
      res_offset <= '0;
      res_bytes  <= cmd.latch_walk ? '0 : total;
    end
  end

  assign sts.clear_done      = clr_cnt[ffa_pkg::ADDR_W];
  assign sts.is_alloc        = (op == ffa_pkg::OP_ALLOC);
  assign sts.walk_end        = (walk >= heap_bytes) || (sz == '0) || !target_ok && op;
  assign sts.fits            = !used && (need <= sz);
  assign sts.split_ok        = rem >= ffa_pkg::MIN_SPLIT;
  assign sts.past_target     = walk > target;
  assign sts.at_target       = walk == target;
  assign sts.next_in_heap    = next_addr < heap_bytes;
  assign sts.have_prev       = have_prev;

  `FFA_ASSERT_IMPL(a_walk_aligned, clk, rst, cmd.latch_walk, walk[2:0] == 3'b000)
  `FFA_ASSERT_IMPL(a_heap_range, clk, rst, 1'b1,
                   heap_bytes >= ffa_pkg::MIN_HEAP && heap_bytes <= ffa_pkg::HEAP_CAP)
  `FFA_ASSERT_NEXT(a_load_rewinds, clk, rst, cmd.load_item, walk == '0)

endmodule

### sv/ffa_ctrl.sv
// ---------------------------------------------------------------------------
// Allocator controller
// Sequences the heap clear, the block walk and the tag updates.
// ---------------------------------------------------------------------------
`include "first_fit_boundary_tag_allocator_assert.svh"

module ffa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output ffa_pkg::cmd_t cmd,
  input  ffa_pkg::sts_t sts
);

  ffa_pkg::state_t state;
  ffa_pkg::state_t state_next;
  logic            fmt_second;
  logic            fmt_second_next;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state      <= ffa_pkg::ST_CLEAR;
      fmt_second <= 1'b0;
    end else begin
      state      <= state_next;
      fmt_second <= fmt_second_next;
    end
  end

  always_comb begin
    state_next      = state;
    fmt_second_next = fmt_second;
    cmd             = '0;
    cmd.rd_sel      = ffa_pkg::RSEL_WALK;
    cmd.wsel        = ffa_pkg::WSEL_NONE;
    in_stall        = 1'b1;
    out_valid       = 1'b0;
    case (state)
      ffa_pkg::ST_CLEAR: begin
        if (sts.clear_done) begin
          state_next = ffa_pkg::ST_FORMAT;
        end else begin
          cmd.clear_step = 1'b1;
        end
      end
      ffa_pkg::ST_FORMAT: begin
        cmd.format_write = 1'b1;
        fmt_second_next  = 1'b1;
        if (fmt_second) begin
          state_next = ffa_pkg::ST_IDLE;
        end
      end
      ffa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ffa_pkg::ST_RD_ISSUE;
        end
      end
      ffa_pkg::ST_RD_ISSUE: begin
        cmd.rd_en  = 1'b1;
        state_next = ffa_pkg::ST_RD_WAIT;
      end
      ffa_pkg::ST_RD_WAIT: begin
        cmd.latch_walk = 1'b1;
        state_next     = ffa_pkg::ST_EXAMINE;
      end
      ffa_pkg::ST_EXAMINE: begin
        if (sts.walk_end || (!sts.is_alloc && sts.past_target)) begin
          if (sts.is_alloc) begin
            cmd.set_fail = 1'b1;
          end else begin
            cmd.set_free_ok = 1'b1;
            cmd.latch_walk  = 1'b1;
          end
          state_next = ffa_pkg::ST_RESULT;
        end else if (sts.is_alloc && sts.fits) begin
          cmd.set_alloc_ok = 1'b1;
          state_next = sts.split_ok ? ffa_pkg::ST_SPLIT_W0 : ffa_pkg::ST_WHOLE_W0;
        end else if (!sts.is_alloc && sts.at_target) begin
          cmd.rd_sel = ffa_pkg::RSEL_NEXT;
          cmd.rd_en  = sts.next_in_heap;
          state_next = sts.next_in_heap ? ffa_pkg::ST_NEXT_WAIT : ffa_pkg::ST_PREV_ISSUE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ffa_pkg::ST_RD_ISSUE;
        end
      end
      ffa_pkg::ST_SPLIT_W0: begin
        cmd.wsel   = ffa_pkg::WSEL_SPLIT_REM_HDR;
        state_next = ffa_pkg::ST_SPLIT_W1;
      end
      ffa_pkg::ST_SPLIT_W1: begin
        cmd.wsel   = ffa_pkg::WSEL_SPLIT_REM_TRL;
        state_next = ffa_pkg::ST_SPLIT_W2;
      end
      ffa_pkg::ST_SPLIT_W2: begin
        cmd.wsel   = ffa_pkg::WSEL_SPLIT_USE_HDR;
        state_next = ffa_pkg::ST_SPLIT_W3;
      end
      ffa_pkg::ST_SPLIT_W3: begin
        cmd.wsel   = ffa_pkg::WSEL_SPLIT_USE_TRL;
        state_next = ffa_pkg::ST_RESULT;
      end
      ffa_pkg::ST_WHOLE_W0: begin
        cmd.wsel   = ffa_pkg::WSEL_WHOLE_HDR;
        state_next = ffa_pkg::ST_WHOLE_W1;
      end
      ffa_pkg::ST_WHOLE_W1: begin
        cmd.wsel   = ffa_pkg::WSEL_WHOLE_TRL;
        state_next = ffa_pkg::ST_RESULT;
      end
      ffa_pkg::ST_NEXT_WAIT: begin
        cmd.latch_next = 1'b1;
        state_next     = ffa_pkg::ST_PREV_ISSUE;
      end
      ffa_pkg::ST_PREV_ISSUE: begin
        cmd.rd_sel = ffa_pkg::RSEL_PREV;
        cmd.rd_en  = sts.have_prev;
        state_next = sts.have_prev ? ffa_pkg::ST_PREV_WAIT : ffa_pkg::ST_MERGE_W0;
      end
      ffa_pkg::ST_PREV_WAIT: begin
        cmd.latch_prev = 1'b1;
        state_next     = ffa_pkg::ST_MERGE_W0;
      end
      ffa_pkg::ST_MERGE_W0: begin
        cmd.wsel   = ffa_pkg::WSEL_MERGE_HDR;
        state_next = ffa_pkg::ST_MERGE_W1;
      end
      ffa_pkg::ST_MERGE_W1: begin
        cmd.wsel        = ffa_pkg::WSEL_MERGE_TRL;
        cmd.set_free_ok = 1'b1;
        state_next      = ffa_pkg::ST_RESULT;
      end
      ffa_pkg::ST_RESULT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffa_pkg::ST_CLEAR;
      end
    endcase
  end

  `FFA_ASSERT_IMPL(a_no_accept_busy, clk, rst, !in_stall, state == ffa_pkg::ST_IDLE)
  `FFA_ASSERT_IMPL(a_one_side, clk, rst, out_valid, in_stall)
  `FFA_ASSERT_NEXT(a_result_holds, clk, rst || cfg_we, out_valid && out_stall, out_valid)

endmodule

### sv/first_fit_boundary_tag_allocator.sv
// ---------------------------------------------------------------------------
// First-fit boundary-tag allocator
// Heap manager that walks header/trailer tags to allocate and free blocks.
// ---------------------------------------------------------------------------
// Usage: a request on the input channel (valid/stall) is allocate or free.
// One result per request appears on the output channel (valid/stall).
// Allocate visits blocks from address 0, each through a read, a wait and
// an examine state, then writes four tags (split) or two. Free walks to
// its block the same way, then reads its neighbors and writes two merged
// tags. One request is in service at a time; the next is taken once the
// result is taken. A stalled result holds its value until taken.
// Reset, and every heap_bytes write, clear the tag memory one word a cycle
// and then write the single free block tags; input stays stalled through
// both. Write heap_bytes only while idle.
// ---------------------------------------------------------------------------
module first_fit_boundary_tag_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [11:0] request_size,
  input  logic [11:0] payload_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [11:0] result_offset,
  output logic [12:0] block_bytes
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffa_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_opcode         (opcode),
    .in_request_size   (request_size),
    .in_payload_offset (payload_offset),
    .cmd               (cmd),
    .sts               (sts),
    .res_status        (status),
    .res_offset        (result_offset),
    .res_bytes         (block_bytes)
  );

endmodule
